[rtl/core/c_subset_byte_lexer_defines.svh]
// Assertion macros shared by the lexer checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef C_SUBSET_BYTE_LEXER_DEFINES_SVH
`define C_SUBSET_BYTE_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CSLX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSLX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cslx_pkg.sv]
// Shared types, codes, keyword tables and character-class functions for
// the byte lexer. No dependencies.
`default_nettype none

package cslx_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_NUM   = 2'd2,
        MODE_STR   = 2'd3
    } lex_mode_t;

    typedef enum logic [1:0] {
        EV_TEXT   = 2'd0,
        EV_DONE   = 2'd1,
        EV_ERROR  = 2'd2,
        EV_FINISH = 2'd3
    } event_t;

    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_INT    = 4'd1;
    localparam logic [3:0] KIND_VOID   = 4'd2;
    localparam logic [3:0] KIND_RETURN = 4'd3;
    localparam logic [3:0] KIND_NUMBER = 4'd4;
    localparam logic [3:0] KIND_STRING = 4'd5;
    localparam logic [3:0] KIND_SEMI   = 4'd6;
    localparam logic [3:0] KIND_LBRACE = 4'd7;
    localparam logic [3:0] KIND_RBRACE = 4'd8;
    localparam logic [3:0] KIND_LPAREN = 4'd9;
    localparam logic [3:0] KIND_RPAREN = 4'd10;

    localparam logic ERR_INVALID_CHAR = 1'b0;
    localparam logic ERR_OPEN_STRING  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_UNDER  = "_";

    localparam int NUM_KW = 3;

    // Keyword spellings, padded with zeros so any 3-bit position is in range.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd6};
    localparam logic [2:0] LEN_MAX = 3'd7;

    typedef struct packed {
        event_t     ev;
        logic [3:0] kind;
        logic [7:0] text;
        logic       err;
        logic       last;
    } lex_result_t;

    // One queue entry holds every result of one input item (one or two).
    typedef struct packed {
        logic        two;
        lex_result_t r0;
        lex_result_t r1;
    } lex_entry_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    // Drop keywords that no longer match after seeing c at position len.
    function automatic logic [2:0] track_cand(input logic [2:0] cand,
                                              input logic [2:0] len,
                                              input logic [7:0] c);
        logic [2:0] res;
        res = cand;
        for (int k = 0; k < NUM_KW; k++) begin
            if (len >= KW_LEN[k] || KW_TEXT[k][len] != c)
                res[k] = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [3:0] ident_kind(input logic [2:0] cand,
                                              input logic [2:0] len);
        logic [3:0] res;
        res = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (cand[k] && len == KW_LEN[k])
                res = 4'(k + 1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cslx_front.sv]
// Lexer front end: takes source bytes, tracks the token state and builds one
// queue entry of results per item. Depends on cslx_pkg.
`default_nettype none

module cslx_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_accept,
    input  wire  [7:0]          source_byte,
    input  wire                 end_of_input,
    output logic                wr_en,
    output cslx_pkg::lex_entry_t wr_entry
);
    import cslx_pkg::*;

    lex_mode_t  mode_reg, mode_next;
    logic [2:0] cand_reg, cand_next;
    logic [2:0] len_reg, len_next;
    logic       halted_reg, halted_next;

    // Handling of a byte seen between tokens.
    logic        idle_has;
    lex_result_t idle_res;
    lex_mode_t   idle_mode;
    logic        idle_halt;
    logic [2:0]  idle_cand;
    logic [2:0]  idle_len;

    logic [3:0]  cur_kind;
    logic [2:0]  len_inc;

    assign cur_kind = ident_kind(cand_reg, len_reg);
    assign len_inc  = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + 3'd1;

    always_comb
    begin
        idle_has       = 1'b0;
        idle_res.ev    = EV_TEXT;
        idle_res.kind  = KIND_IDENT;
        idle_res.text  = 8'h00;
        idle_res.err   = ERR_INVALID_CHAR;
        idle_res.last  = 1'b0;
        idle_mode      = MODE_IDLE;
        idle_halt      = 1'b0;
        idle_cand      = 3'b111;
        idle_len       = 3'd0;
        priority if (is_space(source_byte))
        begin
            idle_has = 1'b0;
        end
        else if (source_byte == CH_QUOTE)
        begin
            idle_mode = MODE_STR;
        end
        else if (source_byte == CH_SEMI || source_byte == CH_LBRACE ||
                 source_byte == CH_RBRACE || source_byte == CH_LPAREN ||
                 source_byte == CH_RPAREN)
        begin
            idle_has    = 1'b1;
            idle_res.ev = EV_DONE;
            priority if (source_byte == CH_SEMI)   idle_res.kind = KIND_SEMI;
            else if (source_byte == CH_LBRACE)     idle_res.kind = KIND_LBRACE;
            else if (source_byte == CH_RBRACE)     idle_res.kind = KIND_RBRACE;
            else if (source_byte == CH_LPAREN)     idle_res.kind = KIND_LPAREN;
            else                                   idle_res.kind = KIND_RPAREN;
        end
        else if (is_alpha(source_byte) || source_byte == CH_UNDER)
        begin
            idle_has      = 1'b1;
            idle_res.text = source_byte;
            idle_mode     = MODE_IDENT;
            idle_cand     = track_cand(3'b111, 3'd0, source_byte);
            idle_len      = 3'd1;
        end
        else if (is_digit(source_byte))
        begin
            idle_has      = 1'b1;
            idle_res.kind = KIND_NUMBER;
            idle_res.text = source_byte;
            idle_mode     = MODE_NUM;
        end
        else
        begin
            idle_has      = 1'b1;
            idle_res.ev   = EV_ERROR;
            idle_res.text = source_byte;
            idle_halt     = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        mode_next   = mode_reg;
        cand_next   = cand_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        if (in_accept && !halted_reg)
        begin
            if (end_of_input)
            begin
                if (mode_reg == MODE_STR)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    cand_next = 3'b111;
                    len_next  = 3'd0;
                end
            end
            else
            begin
                unique case (mode_reg)
                    MODE_STR:
                    begin
                        if (source_byte == CH_QUOTE)
                            mode_next = MODE_IDLE;
                    end
                    MODE_IDENT:
                    begin
                        if (is_ident_char(source_byte))
                        begin
                            cand_next = track_cand(cand_reg, len_reg, source_byte);
                            len_next  = len_inc;
                        end
                        else
                        begin
                            mode_next   = idle_mode;
                            halted_next = idle_halt;
                            cand_next   = idle_cand;
                            len_next    = idle_len;
                        end
                    end
                    MODE_NUM:
                    begin
                        if (!is_digit(source_byte))
                        begin
                            mode_next   = idle_mode;
                            halted_next = idle_halt;
                            cand_next   = idle_cand;
                            len_next    = idle_len;
                        end
                    end
                    MODE_IDLE:
                    begin
                        mode_next   = idle_mode;
                        halted_next = idle_halt;
                        cand_next   = idle_cand;
                        len_next    = idle_len;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // Outputs: the queue entry for this item
    always_comb
    begin
        lex_result_t r0;
        lex_result_t r1;
        logic        has0;
        logic        has1;
        r0.ev   = EV_TEXT;
        r0.kind = KIND_IDENT;
        r0.text = 8'h00;
        r0.err  = ERR_INVALID_CHAR;
        r0.last = 1'b0;
        r1      = r0;
        has0    = 1'b0;
        has1    = 1'b0;
        if (end_of_input)
        begin
            has0 = 1'b1;
            unique case (mode_reg)
                MODE_STR:
                begin
                    r0.ev  = EV_ERROR;
                    r0.err = ERR_OPEN_STRING;
                end
                MODE_IDENT:
                begin
                    r0.ev   = EV_DONE;
                    r0.kind = cur_kind;
                    has1    = 1'b1;
                    r1.ev   = EV_FINISH;
                end
                MODE_NUM:
                begin
                    r0.ev   = EV_DONE;
                    r0.kind = KIND_NUMBER;
                    has1    = 1'b1;
                    r1.ev   = EV_FINISH;
                end
                default:
                begin
                    r0.ev = EV_FINISH;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_STR:
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_STRING;
                    if (source_byte == CH_QUOTE)
                        r0.ev = EV_DONE;
                    else
                        r0.text = source_byte;
                end
                MODE_IDENT:
                begin
                    has0 = 1'b1;
                    if (is_ident_char(source_byte))
                    begin
                        r0.text = source_byte;
                    end
                    else
                    begin
                        r0.ev   = EV_DONE;
                        r0.kind = cur_kind;
                        has1    = idle_has;
                        r1      = idle_res;
                    end
                end
                MODE_NUM:
                begin
                    has0    = 1'b1;
                    r0.kind = KIND_NUMBER;
                    if (is_digit(source_byte))
                    begin
                        r0.text = source_byte;
                    end
                    else
                    begin
                        r0.ev = EV_DONE;
                        has1  = idle_has;
                        r1    = idle_res;
                    end
                end
                default:
                begin
                    has0 = idle_has;
                    r0   = idle_res;
                end
            endcase
        end
        r0.last       = !has1;
        r1.last       = 1'b1;
        wr_entry.two  = has1;
        wr_entry.r0   = r0;
        wr_entry.r1   = r1;
        wr_en         = in_accept && !halted_reg && has0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            cand_reg   <= 3'b111;
            len_reg    <= 3'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            cand_reg   <= cand_next;
            len_reg    <= len_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cslx_queue.sv]
// Short entry queue between the lexer front and back ends.
// Depends on cslx_pkg.
`default_nettype none

module cslx_queue #(
    parameter int DEPTH = cslx_pkg::QUEUE_DEPTH
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  cslx_pkg::lex_entry_t wr_entry,
    input  wire                  rd_en,
    output cslx_pkg::lex_entry_t rd_entry,
    output logic                 q_empty,
    output logic                 q_full
);
    import cslx_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    lex_entry_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign q_empty  = (cnt_reg == '0);
    assign q_full   = (cnt_reg == CNT_FULL);
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cslx_back.sv]
// Lexer back end: splits queue entries into single results and holds the
// oldest one in an output register. Depends on cslx_pkg.
`default_nettype none

module cslx_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_empty,
    input  cslx_pkg::lex_entry_t  q_head,
    output logic                  q_deq,
    input  wire                   pop,
    output logic                  empty,
    output cslx_pkg::lex_result_t res
);
    import cslx_pkg::*;

    logic        out_valid_reg, out_valid_next;
    lex_result_t out_reg, out_next;
    logic        pend_valid_reg, pend_valid_next;
    lex_result_t pend_reg, pend_next;
    logic        load;

    assign empty = !out_valid_reg;
    assign res   = out_reg;
    assign load  = !out_valid_reg || pop;
    assign q_deq = load && !pend_valid_reg && !q_empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (load)
        begin
            priority if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next  = 1'b1;
                out_next        = q_head.r0;
                pend_valid_next = q_head.two;
                pend_next       = q_head.r1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/c_subset_byte_lexer.sv]
// Byte-serial lexer for a small C subset: identifiers, the keywords int,
// void and return, decimal numbers, plain strings and ; { } ( ). One source
// byte (or an end-of-input marker) is taken per push, every cycle while full
// is low. Each byte yields zero, one or two results; results leave through
// an output register at one per cycle while pop is held, so a stream of
// single-result bytes runs at one byte per cycle and each two-result byte
// needs a second output slot. The first result of a byte goes through the
// queue and the output register. The front end writes one entry per byte
// with results into a QUEUE_DEPTH-entry queue; full reflects that queue.
// After an error the block ignores input until reset.
// Depends on cslx_pkg, cslx_front, cslx_queue and cslx_back.
`default_nettype none

module c_subset_byte_lexer #(
    parameter int QUEUE_DEPTH = cslx_pkg::QUEUE_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  source_byte,
    input  wire         end_of_input,
    output logic        empty,
    input  wire         pop,
    output logic [1:0]  event_res,
    output logic [3:0]  token_kind,
    output logic [7:0]  text_byte,
    output logic        error_code,
    output logic        last
);
    import cslx_pkg::*;

    logic        in_accept;
    logic        wr_en;
    lex_entry_t  wr_entry;
    lex_entry_t  q_head;
    logic        q_deq;
    logic        q_empty;
    lex_result_t res;

    assign in_accept = push && !full;

    cslx_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .source_byte  (source_byte),
        .end_of_input (end_of_input),
        .wr_en        (wr_en),
        .wr_entry     (wr_entry)
    );

    cslx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (q_deq),
        .rd_entry (q_head),
        .q_empty  (q_empty),
        .q_full   (full)
    );

    cslx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_deq   (q_deq),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign event_res  = res.ev;
    assign token_kind = res.kind;
    assign text_byte  = res.text;
    assign error_code = res.err;
    assign last       = res.last;

endmodule

`default_nettype wire

[rtl/core/cslx_checker.sv]
// Port-level checks for the lexer, bound to the top level.
// Depends on cslx_pkg and c_subset_byte_lexer_defines.svh.
`default_nettype none

`include "c_subset_byte_lexer_defines.svh"

module cslx_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        empty,
    input wire        pop,
    input wire [1:0]  event_res,
    input wire [3:0]  token_kind,
    input wire [7:0]  text_byte,
    input wire        error_code,
    input wire        last
);
    import cslx_pkg::*;

    // An error or a clean finish is always the final result of its item.
    `CSLX_ASSERT_NOW(a_err_last, !empty && event_res == EV_ERROR, last, "error result not last")
    `CSLX_ASSERT_NOW(a_fin_last, !empty && event_res == EV_FINISH, last, "finish result not last")

    // Text bytes only belong to identifier, number or string tokens.
    `CSLX_ASSERT_NOW(a_text_kind, !empty && event_res == EV_TEXT,
        token_kind == KIND_IDENT || token_kind == KIND_NUMBER || token_kind == KIND_STRING,
        "text byte with bad kind")

    // Error code stays clear on anything but an error.
    `CSLX_ASSERT_NOW(a_err_code, !empty && event_res != EV_ERROR,
        error_code == ERR_INVALID_CHAR, "error code set on non-error result")

    // A waiting result is held until its transfer.
    `CSLX_ASSERT_NEXT(a_hold, !empty && !pop,
        !empty && $stable(event_res) && $stable(text_byte) && $stable(last),
        "stalled result changed")

endmodule

bind c_subset_byte_lexer cslx_checker u_cslx_checker (.*);

`default_nettype wire
